FILE: rtl/imm_pkg.sv
package imm_pkg;

    // Request codes carried in req_type
    localparam logic [1:0] REQ_LOAD_A  = 2'd0;
    localparam logic [1:0] REQ_LOAD_B  = 2'd1;
    localparam logic [1:0] REQ_COMPUTE = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_ROWS_A    = 2'd0;
    localparam logic [1:0] CFG_INNER_DIM = 2'd1;
    localparam logic [1:0] CFG_COLS_B    = 2'd2;

    typedef logic [3:0] t_dim;

    typedef struct packed {
        logic [1:0]         req_type;
        logic [5:0]         elem_index;
        logic signed [31:0] elem_value;
    } t_in_word;

    typedef struct packed {
        logic [2:0]         out_row;
        logic [2:0]         out_col;
        logic signed [31:0] dot_sum;
        logic               last_item;
    } t_out_word;

    typedef enum logic [1:0] {
        S_IDLE,
        S_DOT,
        S_WAIT
    } t_state;

endpackage

FILE: rtl/imm_ram.sv
module imm_ram #(
    parameter int WIDTH  = 32,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: rtl/integer_matrix_multiply_core.sv
// Channel   Direction  Handshake                  Word
// -------   ---------  -------------------------  ----------------------------------
// in        input      i_in_valid / o_in_ready    i_in_word  (t_in_word)
// out       output     o_out_valid / i_out_ready  o_out_word (t_out_word)
// cfg       input      i_cfg_valid / o_cfg_ready  i_cfg_index, i_cfg_data
//
// Loads are accepted back to back while idle.
// A compute word walks rows_a * cols_b product elements of inner_dim terms each: one
// shared 32x32 multiplier does each multiply-accumulate, through the read, multiply
// and add registers. The input is not ready during a run.
// Output stalls hold the sequencer. Reset (synchronous, active low) restores the
// dimensions to MAX_DIM and clears control state; the element stores are not cleared.
module integer_matrix_multiply_core
    import imm_pkg::*;
#(
    parameter int MAX_DIM = 8
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_word  i_in_word,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_word o_out_word,
    input  logic      i_cfg_valid,
    output logic      o_cfg_ready,
    input  logic [1:0] i_cfg_index,
    input  logic [3:0] i_cfg_data
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    // Clamp a raw dimension register into 1..MAX_DIM
    function automatic t_dim eff_dim(input t_dim raw);
        t_dim res;
        res = raw;
        if (raw == 4'd0) begin
            res = 4'd1;
        end else if (raw > 4'(MAX_DIM)) begin
            res = 4'(MAX_DIM);
        end
        return res;
    endfunction

    // Configuration registers
    t_dim r_rows_a, r_inner_dim, r_cols_b;
    t_dim w_m, w_n, w_p;

    // Sequencer
    t_state r_state, n_state;
    logic [IDX_W-1:0]  r_i, r_j, r_k;
    logic [ADDR_W-1:0] r_a_base, r_a_ptr, r_b_ptr;

    // Multiply-accumulate pipeline
    logic        r_rd_vld, r_rd_last;
    logic        r_mul_vld, r_mul_last;
    logic [31:0] r_prod;
    logic [31:0] r_acc;
    logic        r_dot_done;

    // Output register
    logic      r_out_vld;
    t_out_word r_out_word;

    logic        w_in_acc, w_start, w_issue, w_emit, w_slot_free;
    logic        w_k_last, w_j_last, w_i_last;
    logic        w_wr_a, w_wr_b;
    logic [7:0]  w_a_count, w_b_count;
    logic [31:0] w_rd_a, w_rd_b;

    assign w_m = eff_dim(r_rows_a);
    assign w_n = eff_dim(r_inner_dim);
    assign w_p = eff_dim(r_cols_b);

    assign w_k_last = (4'(r_k) == w_n - 4'd1);
    assign w_j_last = (4'(r_j) == w_p - 4'd1);
    assign w_i_last = (4'(r_i) == w_m - 4'd1);

    assign w_a_count = {4'd0, w_m} * {4'd0, w_n};
    assign w_b_count = {4'd0, w_n} * {4'd0, w_p};

    assign w_slot_free = !r_out_vld || i_out_ready;

    // Configuration: always ready, writes beyond the list drop
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rows_a    <= 4'(MAX_DIM);
            r_inner_dim <= 4'(MAX_DIM);
            r_cols_b    <= 4'(MAX_DIM);
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_ROWS_A:    r_rows_a    <= i_cfg_data;
                CFG_INNER_DIM: r_inner_dim <= i_cfg_data;
                CFG_COLS_B:    r_cols_b    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_start) begin
                    n_state = S_DOT;
                end
            end
            S_DOT: begin
                if (w_k_last) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (w_emit) begin
                    n_state = (w_i_last && w_j_last) ? S_IDLE : S_DOT;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer outputs
    always_comb begin
        o_in_ready = 1'b0;
        w_issue    = 1'b0;
        w_emit     = 1'b0;
        case (r_state)
            S_IDLE:  o_in_ready = 1'b1;
            S_DOT:   w_issue    = 1'b1;
            S_WAIT:  w_emit     = r_dot_done && w_slot_free;
            default: ;
        endcase
    end

    assign w_in_acc = i_in_valid && o_in_ready;
    assign w_start  = w_in_acc && (i_in_word.req_type == REQ_COMPUTE);
    // Drop loads that fall outside the configured matrix
    assign w_wr_a = w_in_acc && (i_in_word.req_type == REQ_LOAD_A)
                    && ({2'd0, i_in_word.elem_index} < w_a_count);
    assign w_wr_b = w_in_acc && (i_in_word.req_type == REQ_LOAD_B)
                    && ({2'd0, i_in_word.elem_index} < w_b_count);

    imm_ram #(.WIDTH(32), .DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_ram_a (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_a),
        .i_wr_addr (i_in_word.elem_index[ADDR_W-1:0]),
        .i_wr_data (i_in_word.elem_value),
        .i_rd_en   (w_issue),
        .i_rd_addr (r_a_ptr),
        .o_rd_data (w_rd_a)
    );

    imm_ram #(.WIDTH(32), .DEPTH(DEPTH), .ADDR_W(ADDR_W)) u_ram_b (
        .i_clk     (i_clk),
        .i_wr_en   (w_wr_b),
        .i_wr_addr (i_in_word.elem_index[ADDR_W-1:0]),
        .i_wr_data (i_in_word.elem_value),
        .i_rd_en   (w_issue),
        .i_rd_addr (r_b_ptr),
        .o_rd_data (w_rd_b)
    );

    // State and pipeline control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_rd_vld   <= 1'b0;
            r_rd_last  <= 1'b0;
            r_mul_vld  <= 1'b0;
            r_mul_last <= 1'b0;
            r_dot_done <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_rd_vld   <= w_issue;
            r_rd_last  <= w_issue && w_k_last;
            r_mul_vld  <= r_rd_vld;
            r_mul_last <= r_rd_last;
            if (w_start || w_emit) begin
                r_dot_done <= 1'b0;
            end else if (r_mul_vld && r_mul_last) begin
                r_dot_done <= 1'b1;
            end
        end
    end

    // Index walk and multiply-accumulate datapath
    always_ff @(posedge i_clk) begin
        // Low 32 bits of the product are the same for signed and unsigned
        r_prod <= w_rd_a * w_rd_b;

        if (w_start || w_emit) begin
            r_acc <= '0;
        end else if (r_mul_vld) begin
            r_acc <= r_acc + r_prod;
        end

        if (w_start) begin
            r_i      <= '0;
            r_j      <= '0;
            r_k      <= '0;
            r_a_base <= '0;
            r_a_ptr  <= '0;
            r_b_ptr  <= '0;
        end else if (w_issue) begin
            // Step along row i of A and column j of B
            if (!w_k_last) begin
                r_k     <= r_k + IDX_W'(1);
                r_a_ptr <= r_a_ptr + ADDR_W'(1);
                r_b_ptr <= r_b_ptr + ADDR_W'(w_p);
            end
        end else if (w_emit) begin
            r_k <= '0;
            if (w_j_last) begin
                r_j      <= '0;
                r_i      <= r_i + IDX_W'(1);
                r_a_base <= r_a_base + ADDR_W'(w_n);
                r_a_ptr  <= r_a_base + ADDR_W'(w_n);
                r_b_ptr  <= '0;
            end else begin
                r_j     <= r_j + IDX_W'(1);
                r_a_ptr <= r_a_base;
                r_b_ptr <= ADDR_W'(r_j) + ADDR_W'(1);
            end
        end
    end

    // Output register: hold until taken, reload on emit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (w_emit) begin
            r_out_vld <= 1'b1;
        end else if (i_out_ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_word.out_row   <= 3'(r_i);
            r_out_word.out_col   <= 3'(r_j);
            r_out_word.dot_sum   <= r_acc;
            r_out_word.last_item <= w_i_last && w_j_last;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_word  = r_out_word;

    // The finished sum is complete only once nothing is left in flight
    a_done_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_dot_done |-> (!r_rd_vld && !r_mul_vld))
        else $error("dot product marked done with operands in flight");

    // Stores only change while no run is walking them
    a_store_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_wr_a || w_wr_b) |-> (r_state == S_IDLE && !r_rd_vld && !r_mul_vld))
        else $error("element store written during a run");

    // The inner index stays inside the configured inner dimension
    a_k_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DOT) |-> (4'(r_k) < w_n))
        else $error("inner index beyond inner_dim");

    // The final product element ends the run
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_emit && w_i_last && w_j_last) |=> (r_state == S_IDLE && o_out_word.last_item))
        else $error("run did not end on its final element");

endmodule

FILE: sim/tb.sv
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import imm_pkg::*;

    // Codes the package leaves unnamed: the spare request and register index
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [1:0] CFG_UNUSED = 2'd3;

    localparam int MAX_DIM       = 8;
    localparam int STORE_DEPTH   = MAX_DIM * MAX_DIM;
    localparam int RANDOM_ITEMS  = 110;
    localparam int SETTLE_CYCLES = 8;
    localparam int HOLD_CYCLES   = 300;
    localparam int MAX_REPORTS   = 50;
    // Worst word is a compute of 64 product words, each one behind the longest
    // receiver stall. A few hundred such words still fit well inside this.
    localparam int unsigned CYCLE_LIMIT = 5000000;

    localparam logic [31:0] VAL_MOST_NEG = 32'h8000_0000;
    localparam logic [31:0] VAL_MOST_POS = 32'h7fff_ffff;
    localparam logic [31:0] VAL_ALL_ONES = 32'hffff_ffff;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_in_valid;
    logic       o_in_ready;
    t_in_word   i_in_word;
    logic       o_out_valid;
    logic       i_out_ready;
    t_out_word  o_out_word;
    logic       i_cfg_valid;
    logic       o_cfg_ready;
    logic [1:0] i_cfg_index;
    logic [3:0] i_cfg_data;

    // Shadow copy of the multiplier: raw dimension registers, element stores,
    // and which store entries have been loaded so far.
    t_dim        dim_rows;
    t_dim        dim_inner;
    t_dim        dim_cols;
    logic [31:0] a_elems  [STORE_DEPTH];
    logic [31:0] b_elems  [STORE_DEPTH];
    bit          a_loaded [STORE_DEPTH];
    bit          b_loaded [STORE_DEPTH];

    // Product elements still owed by the block, oldest first
    t_out_word   product_q [$];
    t_out_word   want_word;

    int          mismatch_count = 0;
    int          stim_count     = 0;
    int          rx_hold_len    = 0;
    bit          no_gaps        = 1'b0;

    integer_matrix_multiply_core #(
        .MAX_DIM(MAX_DIM)
    ) u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_in_word  (i_in_word),
        .o_out_valid(o_out_valid),
        .i_out_ready(i_out_ready),
        .o_out_word (o_out_word),
        .i_cfg_valid(i_cfg_valid),
        .o_cfg_ready(o_cfg_ready),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // A zero register acts as one, anything past MAX_DIM acts as MAX_DIM
    function automatic int clamp_dim(t_dim raw);
        if (raw == 0) return 1;
        if (raw > MAX_DIM) return MAX_DIM;
        return int'(raw);
    endfunction

    // Update the shadow stores for one accepted word; on a compute, queue
    // every product element in row-major order using the shape as it is now.
    function automatic void apply_request(t_in_word w);
        int          m;
        int          n;
        int          p;
        logic [31:0] acc;
        t_out_word   elem;
        m = clamp_dim(dim_rows);
        n = clamp_dim(dim_inner);
        p = clamp_dim(dim_cols);
        case (w.req_type)
            REQ_LOAD_A: begin
                if (int'(w.elem_index) < m * n) begin
                    a_elems[w.elem_index]  = w.elem_value;
                    a_loaded[w.elem_index] = 1'b1;
                end
            end
            REQ_LOAD_B: begin
                if (int'(w.elem_index) < n * p) begin
                    b_elems[w.elem_index]  = w.elem_value;
                    b_loaded[w.elem_index] = 1'b1;
                end
            end
            REQ_COMPUTE: begin
                for (int i = 0; i < m; i++) begin
                    for (int j = 0; j < p; j++) begin
                        acc = '0;
                        // 32-bit context: each product and the sum wrap mod 2^32
                        for (int k = 0; k < n; k++) begin
                            acc = acc + a_elems[i * n + k] * b_elems[k * p + j];
                        end
                        elem.out_row   = 3'(i);
                        elem.out_col   = 3'(j);
                        elem.dot_sum   = acc;
                        elem.last_item = (i == m - 1) && (j == p - 1);
                        product_q.push_back(elem);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Result checker: compare each accepted word with the oldest prediction
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS) begin
            $display("[%0t] mismatch on %s: got 0x%08h, want 0x%08h",
                     $time, what, got, want);
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (product_q.size() == 0) begin
                report_mismatch("unexpected result word", o_out_word.dot_sum, '0);
            end else begin
                want_word = product_q.pop_front();
                if (o_out_word.out_row !== want_word.out_row)
                    report_mismatch("out_row", 32'(o_out_word.out_row),
                                    32'(want_word.out_row));
                if (o_out_word.out_col !== want_word.out_col)
                    report_mismatch("out_col", 32'(o_out_word.out_col),
                                    32'(want_word.out_col));
                if (o_out_word.dot_sum !== want_word.dot_sum)
                    report_mismatch("dot_sum", o_out_word.dot_sum, want_word.dot_sum);
                if (o_out_word.last_item !== want_word.last_item)
                    report_mismatch("last_item", 32'(o_out_word.last_item),
                                    32'(want_word.last_item));
            end
        end
    end

    // ------------------------------------------------------------------
    // Idle gaps: mostly none or short, now and then a long one
    // ------------------------------------------------------------------

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 93) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Receiver: drop ready for random gaps; a hold request from the test
    // sequence overrides with one long stretch counted here.
    initial begin : rx_side
        int gap_left;
        gap_left    = 0;
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (rx_hold_len != 0) begin
                gap_left    = rx_hold_len;
                rx_hold_len = 0;
            end
            if (gap_left > 0) begin
                i_out_ready <= 1'b0;
                gap_left--;
            end else begin
                i_out_ready <= 1'b1;
                if (!no_gaps && $urandom_range(0, 3) == 0) gap_left = pick_gap();
            end
        end
    end

    // Watchdog: end the run if it hangs
    initial begin : watchdog
        int unsigned cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus helpers. Every task starts and ends just after a falling edge.
    // ------------------------------------------------------------------

    // Mix of extremes, small signed values and full-range noise
    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 9);
        case (r)
            0:       return VAL_MOST_NEG;
            1:       return VAL_MOST_POS;
            2:       return VAL_ALL_ONES;
            3:       return '0;
            4, 5:    return 32'(int'($urandom_range(0, 15)) - 8);
            default: return $urandom;
        endcase
    endfunction

    // Offer one word, hold it until accepted, then update the predictor
    task automatic send_word(input logic [1:0] req, input logic [5:0] idx,
                             input logic [31:0] val);
        t_in_word w;
        int       gap;
        int       m;
        int       n;
        int       p;
        w.req_type   = req;
        w.elem_index = idx;
        w.elem_value = val;
        gap = no_gaps ? 0 : pick_gap();
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_word  <= w;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        m = clamp_dim(dim_rows);
        n = clamp_dim(dim_inner);
        p = clamp_dim(dim_cols);
        // count only words the block acts on
        if (req == REQ_COMPUTE || (req == REQ_LOAD_A && int'(idx) < m * n)
                || (req == REQ_LOAD_B && int'(idx) < n * p))
            stim_count++;
        apply_request(w);
        @(negedge i_clk);
    endtask

    // Drop valid and wait until every predicted word has come back
    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(negedge i_clk); while (product_q.size() != 0);
    endtask

    // Write one register once the block is idle
    task automatic cfg_write(input logic [1:0] idx, input t_dim data);
        drain_results();
        // a trailing load gives no word back; let it land first
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        i_cfg_valid <= 1'b1;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            CFG_ROWS_A:    dim_rows  = data;
            CFG_INNER_DIM: dim_inner = data;
            CFG_COLS_B:    dim_cols  = data;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic apply_shape(input t_dim rows, input t_dim inner, input t_dim cols);
        cfg_write(CFG_ROWS_A, rows);
        cfg_write(CFG_INNER_DIM, inner);
        cfg_write(CFG_COLS_B, cols);
    endtask

    // Load every element the current shape reads that was never written,
    // so a compute never touches an undefined store entry
    task automatic fill_missing();
        int m;
        int n;
        int p;
        m = clamp_dim(dim_rows);
        n = clamp_dim(dim_inner);
        p = clamp_dim(dim_cols);
        for (int x = 0; x < m * n; x++) begin
            if (!a_loaded[x]) send_word(REQ_LOAD_A, 6'(x), pick_value());
        end
        for (int x = 0; x < n * p; x++) begin
            if (!b_loaded[x]) send_word(REQ_LOAD_B, 6'(x), pick_value());
        end
    endtask

    task automatic load_and_compute();
        fill_missing();
        send_word(REQ_COMPUTE, 6'($urandom), $urandom);
    endtask

    // One load/compute sequence with random content: a few overwrites,
    // some dropped words, then usually a compute
    task automatic run_sequence();
        int a_cnt;
        int b_cnt;
        int r;
        a_cnt = clamp_dim(dim_rows) * clamp_dim(dim_inner);
        b_cnt = clamp_dim(dim_inner) * clamp_dim(dim_cols);
        repeat ($urandom_range(0, 6)) begin
            r = $urandom_range(0, 99);
            if (r < 40) begin
                send_word(REQ_LOAD_A, 6'($urandom_range(0, a_cnt - 1)), pick_value());
            end else if (r < 80) begin
                send_word(REQ_LOAD_B, 6'($urandom_range(0, b_cnt - 1)), pick_value());
            end else if (r < 90) begin
                // index past the configured matrix: the block must drop it
                if (a_cnt < STORE_DEPTH)
                    send_word(REQ_LOAD_A, 6'($urandom_range(a_cnt, STORE_DEPTH - 1)),
                              pick_value());
                else if (b_cnt < STORE_DEPTH)
                    send_word(REQ_LOAD_B, 6'($urandom_range(b_cnt, STORE_DEPTH - 1)),
                              pick_value());
            end else begin
                send_word(REQ_UNUSED, 6'($urandom), $urandom);
            end
        end
        // leave some sequences without a compute
        if ($urandom_range(0, 7) != 0) load_and_compute();
        if ($urandom_range(0, 3) == 0) drain_results();
    endtask

    function automatic t_dim rand_dim();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0) return 4'd0;
        if (r == 1) return 4'd15;
        return t_dim'($urandom_range(1, 4));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Extreme element values, dropped loads, the spare request code, and a
    // single-element product with every dimension clamped up from zero
    task automatic test_boundary_values();
        apply_shape(4'd2, 4'd2, 4'd2);
        send_word(REQ_LOAD_A, 6'd0, VAL_MOST_NEG);
        send_word(REQ_LOAD_A, 6'd1, VAL_MOST_POS);
        send_word(REQ_LOAD_A, 6'd2, VAL_ALL_ONES);
        send_word(REQ_LOAD_A, 6'd3, 32'd1);
        send_word(REQ_LOAD_B, 6'd0, VAL_MOST_NEG);
        send_word(REQ_LOAD_B, 6'd1, VAL_ALL_ONES);
        send_word(REQ_LOAD_B, 6'd2, VAL_MOST_POS);
        send_word(REQ_LOAD_B, 6'd3, 32'h5555_5555);
        send_word(REQ_LOAD_A, 6'd4, 32'h1234_5678);
        send_word(REQ_LOAD_A, 6'd63, VAL_ALL_ONES);
        send_word(REQ_LOAD_B, 6'd63, VAL_MOST_POS);
        send_word(REQ_UNUSED, 6'd63, VAL_ALL_ONES);
        send_word(REQ_COMPUTE, 6'd0, '0);
        apply_shape(4'd0, 4'd0, 4'd0);
        send_word(REQ_COMPUTE, 6'd63, VAL_ALL_ONES);
        drain_results();
    endtask

    // Writes to the spare register index must leave the shape alone
    task automatic test_unused_register();
        cfg_write(CFG_UNUSED, 4'hf);
        cfg_write(CFG_UNUSED, 4'h0);
        load_and_compute();
    endtask

    // Walk shapes that hit each register's extremes; later shapes reuse
    // elements loaded under earlier ones
    task automatic test_shape_sweep();
        apply_shape(4'd3, 4'd4, 4'd2);
        run_sequence();
        run_sequence();
        apply_shape(4'd0, 4'd15, 4'd1);
        load_and_compute();
        // hold the sender until the product is fully back
        drain_results();
        run_sequence();
        no_gaps = 1'b1;
        apply_shape(4'd1, 4'd1, 4'd1);
        run_sequence();
        run_sequence();
        no_gaps = 1'b0;
        apply_shape(4'd6, 4'd6, 4'd1);
        run_sequence();
        apply_shape(4'd2, 4'd8, 4'd3);
        run_sequence();
        no_gaps = 1'b1;
        apply_shape(4'd8, 4'd1, 4'd8);
        load_and_compute();
        no_gaps = 1'b0;
    endtask

    // Stall the output long enough to back the block up while more words
    // keep being offered on the input
    task automatic test_output_backpressure();
        apply_shape(4'd15, 4'd0, 4'd8);
        fill_missing();
        rx_hold_len = HOLD_CYCLES;
        send_word(REQ_COMPUTE, 6'($urandom), $urandom);
        run_sequence();
        run_sequence();
    endtask

    task automatic test_random_shapes();
        do begin
            apply_shape(rand_dim(), rand_dim(), rand_dim());
            repeat ($urandom_range(1, 3)) run_sequence();
        end while (stim_count < RANDOM_ITEMS);
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_in_word   = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = CFG_ROWS_A;
        i_cfg_data  = '0;
        dim_rows    = t_dim'(MAX_DIM);
        dim_inner   = t_dim'(MAX_DIM);
        dim_cols    = t_dim'(MAX_DIM);
        for (int x = 0; x < STORE_DEPTH; x++) begin
            a_elems[x]  = '0;
            b_elems[x]  = '0;
            a_loaded[x] = 1'b0;
            b_loaded[x] = 1'b0;
        end
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        test_boundary_values();
        test_unused_register();
        // count the random part on its own
        stim_count = 0;
        test_shape_sweep();
        test_output_backpressure();
        test_random_shapes();

        drain_results();
        // watch for stray words after the last expected one
        repeat (20) @(negedge i_clk);
        if (mismatch_count == 0 && product_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
